// ===== rtl/core/q4kd_pkg.sv =====
// Shared types and constants for the Q4_K by Q8_K super-block dot core.
// Holds the opcodes, controller states and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package q4kd_pkg;

  // Elements in one super-block, and the derived data-chunk count.
  localparam int unsigned SUPER_BLOCK_LEN = 256;
  localparam int unsigned CHUNKS          = SUPER_BLOCK_LEN / 8;
  localparam logic [4:0]  LAST_CHUNK      = 5'(CHUNKS - 1);

  // Header words and scale bytes.
  localparam logic [4:0]  HDR_WORDS       = 5'd3;
  localparam int unsigned SCALE_BYTES     = 12;

  // Field widths.
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ACT_W   = 8;
  localparam int unsigned DOT_W   = 26;
  localparam int unsigned COR_W   = 22;
  localparam int unsigned LANES   = 4;

  // Packed stream widths; the data widths are padded to whole bytes.
  localparam int unsigned S_DATA_W = 104;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_BSUM   = 2'd1,
    OP_CHUNK  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the input beat.
    logic mul;      // Form partial sums and pick scales.
    logic acc;      // Update accumulators and scale bytes.
    logic emit;     // Load the output register and clear accumulators.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_chunk;  // Held item is the final data chunk.
  } status_t;

endpackage

// ===== rtl/core/q4kd_ctrl.sv =====
// Controller for the super-block dot core: input handshake, step sequencing
// and output valid. Depends on q4kd_pkg.
`timescale 1ns / 1ps

module q4kd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  q4kd_pkg::status_t status_i,
  output q4kd_pkg::cmd_t    cmd_o
);
  import q4kd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_blocked;

  // The output register cannot take a new result while a beat waits there.
  assign out_blocked = out_valid_q && !out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MUL;
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (!(status_i.last_chunk && out_blocked)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_MUL: cmd_o.mul = 1'b1;
      S_ACC: begin
        if (!(status_i.last_chunk && out_blocked)) begin
          cmd_o.acc  = 1'b1;
          cmd_o.emit = status_i.last_chunk;
        end
      end
      default: ;
    endcase
  end

  // Output valid: set by a new result, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/q4kd_dpath.sv =====
// Datapath for the super-block dot core: input latch, scale store and decode,
// nibble products, accumulators and output register. Depends on q4kd_pkg.
`timescale 1ns / 1ps

module q4kd_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  q4kd_pkg::cmd_t                      cmd_i,
  output q4kd_pkg::status_t                   status_o,
  input  q4kd_pkg::opcode_e                   opcode_i,
  input  logic [q4kd_pkg::IDX_W-1:0]          item_index_i,
  input  logic [q4kd_pkg::WORD_W-1:0]         packed_word_i,
  input  logic signed [q4kd_pkg::ACT_W-1:0]   x_low_i  [q4kd_pkg::LANES],
  input  logic signed [q4kd_pkg::ACT_W-1:0]   x_high_i [q4kd_pkg::LANES],
  output logic signed [q4kd_pkg::DOT_W-1:0]   dot_sum_o,
  output logic signed [q4kd_pkg::COR_W-1:0]   min_correction_o
);
  import q4kd_pkg::*;

  // Latched input beat.
  opcode_e                  op_q;
  logic [IDX_W-1:0]         idx_q;
  logic [WORD_W-1:0]        word_q;
  logic signed [ACT_W-1:0]  xl_q [LANES];
  logic signed [ACT_W-1:0]  xh_q [LANES];

  // Scale and min bytes, written by header beats.
  logic [7:0]               scale_q [SCALE_BYTES];
  logic [5:0]               dec_scale [8];
  logic [5:0]               dec_min [8];

  // Partial-sum stage.
  logic signed [13:0]       lo_sum_d, hi_sum_d, lo_sum_q, hi_sum_q;
  logic [5:0]               sc_lo_q, sc_hi_q, min_q;
  logic signed [16:0]       pair_d, pair_q;

  // Accumulators and output register.
  logic signed [DOT_W-1:0]  dot_acc_q, dot_acc_d, dot_out_q;
  logic signed [COR_W-1:0]  cor_acc_q, cor_acc_d, cor_out_q;
  logic signed [20:0]       term_lo, term_hi;
  logic signed [21:0]       dot_term;
  logic signed [COR_W-1:0]  cor_term;
  logic [1:0]               grp;

  assign status_o.last_chunk = (op_q == OP_CHUNK) && (idx_q == LAST_CHUNK);
  assign grp = idx_q[4:3];

  // Latch the accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      idx_q  <= item_index_i;
      word_q <= packed_word_i;
      xl_q   <= x_low_i;
      xh_q   <= x_high_i;
    end
  end

  // Unpack the 6-bit scales and mins from the twelve header bytes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dec_scale[i]   = scale_q[i][5:0];
      dec_min[i]     = scale_q[4+i][5:0];
      dec_scale[4+i] = {scale_q[i][7:6], scale_q[8+i][3:0]};
      dec_min[4+i]   = {scale_q[4+i][7:6], scale_q[8+i][7:4]};
    end
  end

  // Nibble times activation, summed per half; block-sum pair.
  always_comb begin
    logic signed [12:0] p_lo, p_hi;
    lo_sum_d = '0;
    hi_sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      p_lo = $signed({9'b0, word_q[8*i +: 4]}) * $signed({{5{xl_q[i][7]}}, xl_q[i]});
      p_hi = $signed({9'b0, word_q[8*i+4 +: 4]}) * $signed({{5{xh_q[i][7]}}, xh_q[i]});
      lo_sum_d = lo_sum_d + {p_lo[12], p_lo};
      hi_sum_d = hi_sum_d + {p_hi[12], p_hi};
    end
    pair_d = $signed({word_q[15], word_q[15:0]}) + $signed({word_q[31], word_q[31:16]});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      lo_sum_q <= lo_sum_d;
      hi_sum_q <= hi_sum_d;
      pair_q   <= pair_d;
      sc_lo_q  <= dec_scale[{grp, 1'b0}];
      sc_hi_q  <= dec_scale[{grp, 1'b1}];
      min_q    <= dec_min[idx_q[2:0]];
    end
  end

  // Scaled terms for a data chunk and for a block-sum pair.
  always_comb begin
    logic signed [23:0] cor_full;
    term_lo  = $signed({{7{lo_sum_q[13]}}, lo_sum_q}) * $signed({15'b0, sc_lo_q});
    term_hi  = $signed({{7{hi_sum_q[13]}}, hi_sum_q}) * $signed({15'b0, sc_hi_q});
    dot_term = $signed({term_lo[20], term_lo}) + $signed({term_hi[20], term_hi});
    cor_full = $signed({{7{pair_q[16]}}, pair_q}) * $signed({18'b0, min_q});
    cor_term = cor_full[COR_W-1:0];
  end

  // Accumulator update per opcode.
  always_comb begin
    dot_acc_d = dot_acc_q;
    cor_acc_d = cor_acc_q;
    case (op_q)
      OP_BSUM: begin
        if (idx_q[4:3] == 2'b00) cor_acc_d = cor_acc_q + cor_term;
      end
      OP_CHUNK: dot_acc_d = dot_acc_q + {{(DOT_W-22){dot_term[21]}}, dot_term};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_acc_q <= '0;
      cor_acc_q <= '0;
    end else if (cmd_i.acc) begin
      if (cmd_i.emit) begin
        dot_acc_q <= '0;
        cor_acc_q <= '0;
      end else begin
        dot_acc_q <= dot_acc_d;
        cor_acc_q <= cor_acc_d;
      end
    end
  end

  // Header writes land in the scale store during the accumulate step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && (op_q == OP_HEADER) && (idx_q < HDR_WORDS)) begin
      for (int k = 0; k < 4; k++) begin
        scale_q[{idx_q[1:0], 2'(k)}] <= word_q[8*k +: 8];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dot_out_q <= dot_acc_d;
      cor_out_q <= cor_acc_d;
    end
  end

  assign dot_sum_o        = dot_out_q;
  assign min_correction_o = cor_out_q;

endmodule

// ===== rtl/core/q4k_q8k_integer_dot.sv =====
// Top level of the Q4_K by Q8_K super-block integer dot core.
// Instantiates q4kd_ctrl and q4kd_dpath; depends on q4kd_pkg.
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser: opcode; tdata: item fields
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: dot_sum, min_correction
//
// Each input beat passes through capture, partial products and accumulate; no
// new beat is taken until the controller's three-step sequence over one datapath ends.
// Reset clears the controller, output valid and both accumulators; the scale
// bytes hold no reset value until a header beat writes them.
// Input beats keep flowing while a result waits; only a final data chunk
// stalls in its accumulate step until the output register is free.
`timescale 1ns / 1ps

module q4k_q8k_integer_dot (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] item_index, [36:5] packed_word, [44:37] x_low_0, [52:45] x_low_1,
  // [60:53] x_low_2, [68:61] x_low_3, [76:69] x_high_0, [84:77] x_high_1,
  // [92:85] x_high_2, [100:93] x_high_3, [103:101] zero
  input  logic [q4kd_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [q4kd_pkg::S_USER_W-1:0] s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [25:0] dot_sum, [47:26] min_correction
  output logic [q4kd_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import q4kd_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  opcode_e                 opcode;
  logic signed [ACT_W-1:0] x_low  [LANES];
  logic signed [ACT_W-1:0] x_high [LANES];
  logic signed [DOT_W-1:0] dot_sum;
  logic signed [COR_W-1:0] min_correction;

  // Unpack the input beat.
  assign opcode = opcode_e'(s_axis_tuser[1:0]);
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      x_low[i]  = s_axis_tdata[37 + ACT_W*i +: ACT_W];
      x_high[i] = s_axis_tdata[69 + ACT_W*i +: ACT_W];
    end
  end

  q4kd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  q4kd_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode),
    .item_index_i     (s_axis_tdata[4:0]),
    .packed_word_i    (s_axis_tdata[36:5]),
    .x_low_i          (x_low),
    .x_high_i         (x_high),
    .dot_sum_o        (dot_sum),
    .min_correction_o (min_correction)
  );

  // Pack the result beat.
  assign m_axis_tdata = {min_correction, dot_sum};

  // A new result never overwrites a beat that is still waiting.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result loaded while output register was held");

  // A result shows up on the output the cycle after it is produced.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid)
    else $error("emitted result not presented");

  // After an accepted beat the input stays closed while it is processed.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && cmd.mul))
    else $error("input reopened before processing");

  // An accumulate step is never issued while the input is open.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.acc |-> !s_axis_tready)
    else $error("accumulate issued while idle");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the Q4_K by Q8_K super-block integer dot core.
// Drives directed and random beats over the input stream; checks each output beat against
// a predictor or a row's expected value; depends on q4kd_pkg and q4k_q8k_integer_dot.
`timescale 1ns / 1ps

module tb;
  import q4kd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned TARGET_BEATS = 1500;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned SUB_BLOCKS   = 8;

  // One input beat, with the fields held apart.
  typedef struct packed {
    opcode_e                     op;
    logic [IDX_W-1:0]            idx;
    logic [WORD_W-1:0]           word;
    logic [LANES-1:0][ACT_W-1:0] xl;
    logic [LANES-1:0][ACT_W-1:0] xh;
  } beat_t;

  typedef struct packed {
    logic [DOT_W-1:0] dot;
    logic [COR_W-1:0] cor;
  } dot_result_t;

  typedef struct {
    beat_t       b;
    bit          typed;
    dot_result_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [S_USER_W-1:0] s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // Predictor state.
  logic [7:0]       scale_mem [SCALE_BYTES];
  logic [DOT_W-1:0] dot_acc;
  logic [COR_W-1:0] cor_acc;

  dot_result_t pending_dots[$];
  dir_row_t    directed_rows[$];

  int unsigned errors        = 0;
  int unsigned results_seen  = 0;
  int unsigned beats_sent    = 0;
  int unsigned beats_ignored = 0;
  int unsigned cycle_count   = 0;
  bit          calm          = 1'b0;

  q4k_q8k_integer_dot dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run-time guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still due", $time, pending_dots.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sub-block scale and min decode from the twelve header bytes.
  function automatic int decode_scale(int s);
    int         i;
    logic [5:0] v;
    i = s & 3;
    if (s < 4) v = scale_mem[i][5:0];
    else       v = {scale_mem[i][7:6], scale_mem[8+i][3:0]};
    return int'(v);
  endfunction

  function automatic int decode_min(int s);
    int         i;
    logic [5:0] v;
    i = s & 3;
    if (s < 4) v = scale_mem[4+i][5:0];
    else       v = {scale_mem[4+i][7:6], scale_mem[8+i][7:4]};
    return int'(v);
  endfunction

  // Advance the predictor by one beat; returns 1 when the beat closes a super-block.
  function automatic bit predict_dot(input beat_t b, output dot_result_t r);
    int lo, hi, nib, act, pair, term, g;
    logic [7:0] wb;
    r  = '0;
    lo = 0;
    hi = 0;
    case (b.op)
      OP_HEADER: begin
        if (b.idx < HDR_WORDS)
          for (int i = 0; i < 4; i++) scale_mem[b.idx*4+i] = b.word[8*i +: 8];
      end
      OP_BSUM: begin
        if (b.idx < SUB_BLOCKS) begin
          pair = int'($signed(b.word[15:0])) + int'($signed(b.word[31:16]));
          term = decode_min(b.idx) * pair;
          cor_acc = cor_acc + term[COR_W-1:0];
        end
      end
      OP_CHUNK: begin
        g = b.idx[4:3];
        for (int i = 0; i < LANES; i++) begin
          wb  = b.word[8*i +: 8];
          nib = wb[3:0];
          act = $signed(b.xl[i]);
          lo += nib * act;
          nib = wb[7:4];
          act = $signed(b.xh[i]);
          hi += nib * act;
        end
        term = lo * decode_scale(2*g) + hi * decode_scale(2*g + 1);
        dot_acc = dot_acc + term[DOT_W-1:0];
        if (b.idx == LAST_CHUNK) begin
          r.dot   = dot_acc;
          r.cor   = cor_acc;
          dot_acc = '0;
          cor_acc = '0;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit is_ignored(beat_t b);
    return (b.op == OP_RSVD) || (b.op == OP_HEADER && b.idx >= HDR_WORDS) ||
           (b.op == OP_BSUM && b.idx >= SUB_BLOCKS);
  endfunction

  // Present one beat, wait for it to be taken, then log what it should produce.
  task automatic send_beat(input beat_t b, input bit typed, input dot_result_t want);
    dot_result_t got;
    s_axis_tuser  <= b.op;
    s_axis_tdata  <= S_DATA_W'({b.xh, b.xl, b.word, b.idx});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_dot(b, got)) begin
      pending_dots.push_back(typed ? want : got);
    end
    beats_sent++;
    if (is_ignored(b)) beats_ignored++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  function automatic void add_row(opcode_e op, int idx, logic [31:0] word,
                                  logic [31:0] xl, logic [31:0] xh,
                                  bit typed = 1'b0, int want_dot = 0, int want_cor = 0);
    dir_row_t r;
    r.b.op     = op;
    r.b.idx    = idx[IDX_W-1:0];
    r.b.word   = word;
    r.b.xl     = xl;
    r.b.xh     = xh;
    r.typed    = typed;
    r.want.dot = want_dot[DOT_W-1:0];
    r.want.cor = want_cor[COR_W-1:0];
    directed_rows.push_back(r);
  endfunction

  // Random beat; block sums mostly stay in the range real activations give.
  function automatic beat_t random_beat(opcode_e op, int idx);
    beat_t b;
    int    mode;
    b.op   = op;
    b.idx  = idx[IDX_W-1:0];
    b.word = $urandom;
    for (int i = 0; i < LANES; i++) begin
      b.xl[i] = ACT_W'($urandom);
      b.xh[i] = ACT_W'($urandom);
    end
    if (op == OP_BSUM && $urandom_range(0, 7) != 0) begin
      b.word[15:0]  = 16'($urandom_range(0, 4080)) - 16'd2048;
      b.word[31:16] = 16'($urandom_range(0, 4080)) - 16'd2048;
    end
    if (op == OP_CHUNK) begin
      mode = $urandom_range(0, 15);
      if (mode == 0) begin
        b.word = 32'hFFFF_FFFF;
        b.xl   = 32'h8080_8080;
        b.xh   = 32'h8080_8080;
      end else if (mode == 1) begin
        b.word = 32'hFFFF_FFFF;
        b.xl   = 32'h7F7F_7F7F;
        b.xh   = 32'h7F7F_7F7F;
      end
    end
    return b;
  endfunction

  // Compare each output beat with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    dot_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_dots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual dot_sum=%0d corr=%0d",
                 $time, $signed(m_axis_tdata[DOT_W-1:0]),
                 $signed(m_axis_tdata[DOT_W+COR_W-1:DOT_W]));
      end else begin
        want = pending_dots.pop_front();
        results_seen++;
        if (m_axis_tdata[DOT_W-1:0] !== want.dot) begin
          errors++;
          $display("%0t: dot_sum mismatch, expected %0d, actual %0d", $time,
                   $signed(want.dot), $signed(m_axis_tdata[DOT_W-1:0]));
        end
        if (m_axis_tdata[DOT_W+COR_W-1:DOT_W] !== want.cor) begin
          errors++;
          $display("%0t: min_correction mismatch, expected %0d, actual %0d", $time,
                   $signed(want.cor), $signed(m_axis_tdata[DOT_W+COR_W-1:DOT_W]));
        end
      end
    end
  end

  // Output side back-pressure in random bursts.
  initial begin
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  // Stimulus: directed table, then random super-blocks, noise and broken sequences.
  initial begin
    dot_result_t none;
    beat_t       b;
    int          mode, n;
    none    = '0;
    dot_acc = '0;
    cor_acc = '0;
    foreach (scale_mem[k]) scale_mem[k] = '0;

    // All scale bytes are written first, so no later beat reads an unwritten one.
    add_row(OP_HEADER, 0, 32'hFFFF_FFFF, 32'h0, 32'h0);
    add_row(OP_HEADER, 1, 32'hFFFF_FFFF, 32'h0, 32'h0);
    add_row(OP_HEADER, 2, 32'hFFFF_FFFF, 32'h0, 32'h0);
    // Full scales, full nibbles, most negative and most positive activations.
    add_row(OP_CHUNK, LAST_CHUNK, 32'hFFFF_FFFF, 32'h8080_8080, 32'h8080_8080,
            1'b1, -967680, 0);
    add_row(OP_CHUNK, LAST_CHUNK, 32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h7F7F_7F7F,
            1'b1, 960120, 0);
    // Extreme block sums wrap the correction; out-of-range indexes and opcode 3 do nothing.
    add_row(OP_BSUM, 0, 32'h8000_8000, 32'h0, 32'h0);
    add_row(OP_BSUM, 7, 32'h7FFF_7FFF, 32'h0, 32'h0);
    add_row(OP_BSUM, 8, 32'h1234_5678, 32'h0, 32'h0);
    add_row(OP_HEADER, 31, 32'h0000_0000, 32'h0, 32'h0);
    add_row(OP_RSVD, LAST_CHUNK, 32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h7F7F_7F7F);
    // One chunk in each group, then the closing chunk.
    add_row(OP_CHUNK, 0, 32'h0F0F_0F0F, 32'h807F_807F, 32'h7F80_7F80);
    add_row(OP_CHUNK, 8, 32'hF0F0_F0F0, 32'h8080_8080, 32'h7F7F_7F7F);
    add_row(OP_CHUNK, 16, 32'h5A5A_A5A5, 32'h01FF_7F80, 32'h80FF_017F);
    add_row(OP_CHUNK, 24, 32'hFFFF_FFFF, 32'h7F7F_7F7F, 32'h7F7F_7F7F);
    add_row(OP_CHUNK, LAST_CHUNK, 32'h0000_0000, 32'h8080_8080, 32'h8080_8080);
    // Zero scales give a zero result.
    add_row(OP_HEADER, 0, 32'h0000_0000, 32'h0, 32'h0);
    add_row(OP_HEADER, 1, 32'h0000_0000, 32'h0, 32'h0);
    add_row(OP_HEADER, 2, 32'h0000_0000, 32'h0, 32'h0);
    add_row(OP_CHUNK, LAST_CHUNK, 32'hFFFF_FFFF, 32'h8080_8080, 32'h8080_8080,
            1'b1, 0, 0);
    // Mixed header bits exercise the split high-sub-block decode.
    add_row(OP_HEADER, 0, 32'hC080_4001, 32'h0, 32'h0);
    add_row(OP_HEADER, 1, 32'h7F3F_C081, 32'h0, 32'h0);
    add_row(OP_HEADER, 2, 32'hA55A_F00F, 32'h0, 32'h0);
    add_row(OP_BSUM, 3, 32'h0001_0001, 32'h0, 32'h0);
    add_row(OP_BSUM, 4, 32'h07F0_F810, 32'h0, 32'h0);
    add_row(OP_CHUNK, LAST_CHUNK, 32'h8765_4321, 32'h0381_7F05, 32'hF9C0_2A80);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k])
      send_beat(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].want);

    while (beats_sent < TARGET_BEATS) begin
      calm = beats_sent > (TARGET_BEATS * 17) / 20;
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
        // Well-formed super-block with random content.
        for (int h = 0; h < HDR_WORDS; h++) send_beat(random_beat(OP_HEADER, h), 1'b0, none);
        for (int j = 0; j < SUB_BLOCKS; j++) send_beat(random_beat(OP_BSUM, j), 1'b0, none);
        for (int c = 0; c < CHUNKS; c++) send_beat(random_beat(OP_CHUNK, c), 1'b0, none);
      end else if (mode == 7) begin
        // Broken sequence: stale scales, repeated or out-of-order items, then a close.
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          b = random_beat(opcode_e'($urandom_range(0, 1) ? OP_BSUM : OP_CHUNK),
                          $urandom_range(0, 31));
          send_beat(b, 1'b0, none);
        end
        send_beat(random_beat(OP_CHUNK, LAST_CHUNK), 1'b0, none);
      end else begin
        // Noise over every opcode and index.
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          b = random_beat(opcode_e'($urandom_range(0, 3)), $urandom_range(0, 31));
          send_beat(b, 1'b0, none);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d input beats (%0d of them ignored by design); checked %0d results.",
             beats_sent, beats_ignored, results_seen);
    $display("Stimulus mixed full super-blocks, broken sequences and noise under back-pressure.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/q4kd_pkg.sv
rtl/core/q4kd_ctrl.sv
rtl/core/q4kd_dpath.sv
rtl/core/q4k_q8k_integer_dot.sv
test/tb.sv
